// ===== rtl/cas_pkg.sv =====
// cave automaton stencil package: column, config and result types, codes
// and sizes shared by the evaluator, the result queue and the top level
// no dependencies
`timescale 1ns / 1ps

package cas_pkg;

  localparam int ColWidth   = 5;
  localparam int CountWidth = 4;
  localparam int CodeWidth  = 2;
  localparam int ModeWidth  = 2;
  localparam int LimitWidth = 4;
  localparam int CfgIdxWidth = 2;
  localparam int CfgDataWidth = 4;

  localparam int QueueDepth = 4;
  localparam int PtrWidth   = $clog2(QueueDepth);
  localparam int FillWidth  = $clog2(QueueDepth + 1);

  // column bit positions
  localparam int ColUpper    = 0;
  localparam int ColMiddle   = 1;
  localparam int ColLower    = 2;
  localparam int ColHasUpper = 3;
  localparam int ColHasLower = 4;

  // rule modes
  localparam logic [ModeWidth-1:0] MODE_STEP   = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_SMOOTH = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_HOLLOW = 2'd2;

  // cell codes
  localparam logic [CodeWidth-1:0] CODE_FLOOR = 2'd0;
  localparam logic [CodeWidth-1:0] CODE_WALL  = 2'd1;
  localparam logic [CodeWidth-1:0] CODE_EMPTY = 2'd2;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] REG_RULE_MODE    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_UNDER_LIMIT  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_OVER_LIMIT   = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_SMOOTH_LIMIT = 2'd3;

  localparam logic [LimitWidth-1:0] UNDER_RESET  = 4'd3;
  localparam logic [LimitWidth-1:0] OVER_RESET   = 4'd8;
  localparam logic [LimitWidth-1:0] SMOOTH_RESET = 4'd0;
  localparam logic [CountWidth-1:0] FULL_COUNT   = 4'd8;

  typedef logic [ColWidth-1:0] column_t;

  typedef struct packed {
    logic [ModeWidth-1:0]  rule_mode;
    logic [LimitWidth-1:0] under_limit;
    logic [LimitWidth-1:0] over_limit;
    logic [LimitWidth-1:0] smooth_limit;
  } cfg_t;

  typedef struct packed {
    logic                  run_last;
    logic [CountWidth-1:0] wall_count;
    logic [CodeWidth-1:0]  cell_code;
  } result_t;

endpackage

// ===== rtl/cas_eval.sv =====
// cave automaton stencil rule evaluation for one centre cell
// counts wall neighbours in a three-column window and applies the rule
// depends on cas_pkg
`timescale 1ns / 1ps

module cas_eval (
  input  cas_pkg::column_t                mid,
  input  cas_pkg::column_t                lcol,
  input  logic                            lp,
  input  cas_pkg::column_t                rcol,
  input  logic                            rp,
  input  cas_pkg::cfg_t                   cfg,
  output logic [cas_pkg::CodeWidth-1:0]   code,
  output logic [cas_pkg::CountWidth-1:0]  count
);

  logic [1:0] mid_walls;
  logic [1:0] left_walls;
  logic [1:0] right_walls;
  logic       self_wall;
  logic       corner;
  logic [cas_pkg::CodeWidth-1:0] self_code;

  always_comb begin
    mid_walls = {1'b0, mid[cas_pkg::ColHasUpper] & mid[cas_pkg::ColUpper]}
              + {1'b0, mid[cas_pkg::ColHasLower] & mid[cas_pkg::ColLower]};
    left_walls = {1'b0, lcol[cas_pkg::ColHasUpper] & lcol[cas_pkg::ColUpper]}
               + {1'b0, lcol[cas_pkg::ColMiddle]}
               + {1'b0, lcol[cas_pkg::ColHasLower] & lcol[cas_pkg::ColLower]};
    right_walls = {1'b0, rcol[cas_pkg::ColHasUpper] & rcol[cas_pkg::ColUpper]}
                + {1'b0, rcol[cas_pkg::ColMiddle]}
                + {1'b0, rcol[cas_pkg::ColHasLower] & rcol[cas_pkg::ColLower]};
    count = {2'b00, mid_walls}
          + (lp ? {2'b00, left_walls} : 4'd0)
          + (rp ? {2'b00, right_walls} : 4'd0);
  end

  assign self_wall = mid[cas_pkg::ColMiddle];
  assign self_code = self_wall ? cas_pkg::CODE_WALL : cas_pkg::CODE_FLOOR;
  assign corner = (!lp || !rp) && (!mid[cas_pkg::ColHasUpper] || !mid[cas_pkg::ColHasLower]);

  always_comb begin
    case (cfg.rule_mode)
      cas_pkg::MODE_STEP: begin
        code = (count <= cfg.under_limit || count > cfg.over_limit)
               ? cas_pkg::CODE_WALL : cas_pkg::CODE_FLOOR;
      end
      cas_pkg::MODE_SMOOTH: begin
        code = (!corner && count <= cfg.smooth_limit) ? cas_pkg::CODE_FLOOR : self_code;
      end
      cas_pkg::MODE_HOLLOW: begin
        code = (count == cas_pkg::FULL_COUNT) ? cas_pkg::CODE_EMPTY : self_code;
      end
      default: begin
        code = self_code;
      end
    endcase
  end

endmodule

// ===== rtl/cas_queue.sv =====
// cave automaton stencil result queue: takes up to two results a cycle,
// hands one a cycle to the output stream while pop is high
// depends on cas_pkg
`timescale 1ns / 1ps

module cas_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        push_cnt,
  input  cas_pkg::result_t                  push0,
  input  cas_pkg::result_t                  push1,
  input  logic                              pop,
  output cas_pkg::result_t                  head,
  output logic [cas_pkg::FillWidth-1:0]     fill
);

  cas_pkg::result_t entries [cas_pkg::QueueDepth];
  logic [cas_pkg::PtrWidth-1:0]  wptr;
  logic [cas_pkg::PtrWidth-1:0]  rptr;
  logic [cas_pkg::PtrWidth-1:0]  wptr_plus1;
  logic [cas_pkg::FillWidth-1:0] fill_next;

  assign wptr_plus1 = wptr + 1'b1;
  assign head = entries[rptr];
  assign fill_next = fill + {{(cas_pkg::FillWidth-2){1'b0}}, push_cnt}
                   - {{(cas_pkg::FillWidth-1){1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entries[wptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      entries[wptr_plus1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      wptr <= wptr + push_cnt[cas_pkg::PtrWidth-1:0];
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= cas_pkg::FillWidth'(cas_pkg::QueueDepth))
    else $error("result queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != '0)
    else $error("pop from empty result queue");

endmodule

// ===== rtl/cave_automaton_stencil.sv =====
// cave automaton stencil top level: config registers, column window,
// two rule evaluators and the result queue
// depends on cas_pkg, cas_eval, cas_queue
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   tdata upper..has_lower, tuser row_first, tlast row_last
// m_       out  m_tvalid/m_tready   tdata cell_code, wall_count, tlast run_last
// cfg_     in   cfg_we              cfg_index, cfg_data
//
// one column accepted per cycle while s_tready is high; the window and both
// evaluations are settled in the accept cycle and results land in the queue the next edge
// a row end column yields two results if a centre is pending; the queue drains one per cycle while m_tready is high
// s_tready drops while fewer than two queue slots are free
// rst is synchronous, clears the window and the queue and loads the config register defaults
`timescale 1ns / 1ps

module cave_automaton_stencil (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // upper_wall, middle_wall, lower_wall, has_upper, has_lower, pad
  input  logic                               s_tuser,  // row_first
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,  // cell_code[1:0], wall_count[5:2], pad
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [cas_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [cas_pkg::CfgDataWidth-1:0]   cfg_data
);

  cas_pkg::cfg_t    cfg;
  cas_pkg::column_t left_column;
  cas_pkg::column_t centre_column;
  logic             left_present;
  logic             centre_present;

  cas_pkg::column_t left_column_next;
  logic             left_present_next;
  cas_pkg::column_t x;
  logic             accept;
  logic             first;
  logic             last;
  logic             restart;

  logic [cas_pkg::CodeWidth-1:0]  code0;
  logic [cas_pkg::CountWidth-1:0] count0;
  logic [cas_pkg::CodeWidth-1:0]  code1;
  logic [cas_pkg::CountWidth-1:0] count1;
  cas_pkg::result_t res0;
  cas_pkg::result_t res1;
  cas_pkg::result_t push0;
  cas_pkg::result_t push1;
  logic [1:0]       push_cnt;
  cas_pkg::result_t head;
  logic [cas_pkg::FillWidth-1:0] fill;
  logic             pop;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rule_mode    <= cas_pkg::MODE_STEP;
      cfg.under_limit  <= cas_pkg::UNDER_RESET;
      cfg.over_limit   <= cas_pkg::OVER_RESET;
      cfg.smooth_limit <= cas_pkg::SMOOTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cas_pkg::REG_RULE_MODE:    cfg.rule_mode    <= cfg_data[cas_pkg::ModeWidth-1:0];
        cas_pkg::REG_UNDER_LIMIT:  cfg.under_limit  <= cfg_data[cas_pkg::LimitWidth-1:0];
        cas_pkg::REG_OVER_LIMIT:   cfg.over_limit   <= cfg_data[cas_pkg::LimitWidth-1:0];
        cas_pkg::REG_SMOOTH_LIMIT: cfg.smooth_limit <= cfg_data[cas_pkg::LimitWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  assign x      = s_tdata[cas_pkg::ColWidth-1:0];
  assign first  = s_tuser;
  assign last   = s_tlast;
  assign accept = s_tvalid && s_tready;
  assign s_tready = fill < cas_pkg::FillWidth'(cas_pkg::QueueDepth - 1);

  // new row when flagged or when no centre is pending
  assign restart           = first || !centre_present;
  assign left_column_next  = restart ? '0 : centre_column;
  assign left_present_next = !restart;

  // pending centre, right neighbour is this column unless a new row starts
  cas_eval u_eval_centre (
    .mid   (centre_column),
    .lcol  (left_column),
    .lp    (left_present),
    .rcol  (first ? cas_pkg::column_t'('0) : x),
    .rp    (!first),
    .cfg   (cfg),
    .code  (code0),
    .count (count0)
  );

  // row end: this column has no right neighbour
  cas_eval u_eval_end (
    .mid   (x),
    .lcol  (left_column_next),
    .lp    (left_present_next),
    .rcol  ('0),
    .rp    (1'b0),
    .cfg   (cfg),
    .code  (code1),
    .count (count1)
  );

  always_comb begin
    res0.cell_code  = code0;
    res0.wall_count = count0;
    res0.run_last   = !last;
    res1.cell_code  = code1;
    res1.wall_count = count1;
    res1.run_last   = 1'b1;
    push0    = centre_present ? res0 : res1;
    push1    = res1;
    push_cnt = 2'd0;
    if (accept) begin
      push_cnt = {1'b0, centre_present} + {1'b0, last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_present   <= 1'b0;
      centre_present <= 1'b0;
      left_column    <= '0;
      centre_column  <= '0;
    end else if (accept) begin
      left_column    <= left_column_next;
      centre_column  <= x;
      left_present   <= left_present_next && !last;
      centre_present <= !last;
    end
  end

  cas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .push0    (push0),
    .push1    (push1),
    .pop      (pop),
    .head     (head),
    .fill     (fill)
  );

  assign m_tvalid = fill != '0;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {2'b00, head.wall_count, head.cell_code};
  assign m_tlast  = head.run_last;

  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> !centre_present && !left_present)
    else $error("window not cleared after row end");

  a_open_row: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tlast |=> centre_present)
    else $error("centre missing after column accepted");

  a_left_needs_centre: assert property (@(posedge clk) disable iff (rst)
    left_present |-> centre_present)
    else $error("left column held without centre");

endmodule

// ===== sim/testbench.sv =====
// testbench for cave_automaton_stencil: directed column table, then randomized rows
// under changing rule settings, each result checked against a cycle-free predictor
// or a typed want; depends on cas_pkg and the cave_automaton_stencil rtl
`timescale 1ns / 1ps

module testbench;

  localparam int SettleCycles = 4;
  localparam int HoldCycles   = 250;
  localparam int Phases       = 12;
  localparam int PhaseColumns = 140;
  localparam int CycleLimit   = 500000;
  localparam int Probes       = 31;

  typedef struct packed {
    bit                               is_cfg;
    logic [cas_pkg::CfgIdxWidth-1:0]  reg_idx;
    logic [cas_pkg::CfgDataWidth-1:0] value;
    cas_pkg::column_t                 col;
    bit                               first;
    bit                               last;
    bit                               typed;
    cas_pkg::result_t                 want;
  } probe_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  // upper_wall, middle_wall, lower_wall, has_upper, has_lower, pad
  logic [7:0]                       s_tdata = '0;
  logic                             s_tuser = 1'b0;  // row_first
  logic                             s_tlast = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [7:0]                       m_tdata;  // cell_code[1:0], wall_count[5:2], pad
  logic                             m_tlast;
  logic                             cfg_we = 1'b0;
  logic [cas_pkg::CfgIdxWidth-1:0]  cfg_index = '0;
  logic [cas_pkg::CfgDataWidth-1:0] cfg_data = '0;

  // predictor state
  cas_pkg::cfg_t    live_cfg;
  cas_pkg::column_t left_col, mid_col;
  bit               left_held, mid_held;

  cas_pkg::result_t awaited[$];
  int      mismatches = 0;
  int      cells_checked = 0;
  int      columns_sent = 0;
  int      settings_applied = 0;
  int      cycles = 0;
  bit      window_open = 1'b0;
  bit      src_calm = 1'b0;
  bit      sink_calm = 1'b0;
  bit      hold_sink = 1'b0;

  probe_t directed_rows [Probes] = '{
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b00111, 1'b1, 1'b1, 1'b1,
      '{1'b1, 4'd0, cas_pkg::CODE_WALL}},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11101, 1'b1, 1'b1, 1'b1,
      '{1'b1, 4'd2, cas_pkg::CODE_WALL}},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11111, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11111, 1'b0, 1'b0, 1'b1,
      '{1'b1, 4'd5, cas_pkg::CODE_FLOOR}},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11111, 1'b0, 1'b1, 1'b0, '0},
    // row begun without a first flag
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11000, 1'b0, 1'b0, 1'b0, '0},
    // new row before the old one ended
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11111, 1'b1, 1'b0, 1'b1,
      '{1'b1, 4'd0, cas_pkg::CODE_WALL}},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b00111, 1'b0, 1'b1, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b00010, 1'b0, 1'b1, 1'b0, '0},
    '{1'b1, cas_pkg::REG_RULE_MODE, 4'd2, 5'b00000, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11111, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11111, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11111, 1'b0, 1'b1, 1'b0, '0},
    // row flags differing from column to column
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b01111, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11111, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b10111, 1'b0, 1'b1, 1'b0, '0},
    '{1'b1, cas_pkg::REG_RULE_MODE, 4'd1, 5'b00000, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, cas_pkg::REG_SMOOTH_LIMIT, 4'd4, 5'b00000, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b00010, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11010, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11110, 1'b0, 1'b1, 1'b0, '0},
    // unused mode passes the cell through
    '{1'b1, cas_pkg::REG_RULE_MODE, 4'd3, 5'b00000, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b11111, 1'b1, 1'b1, 1'b1,
      '{1'b1, 4'd2, cas_pkg::CODE_WALL}},
    '{1'b1, cas_pkg::REG_RULE_MODE, 4'd0, 5'b00000, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, cas_pkg::REG_UNDER_LIMIT, 4'd15, 5'b00000, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, cas_pkg::REG_OVER_LIMIT, 4'd15, 5'b00000, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b00000, 1'b1, 1'b1, 1'b1,
      '{1'b1, 4'd0, cas_pkg::CODE_WALL}},
    '{1'b1, cas_pkg::REG_UNDER_LIMIT, 4'd0, 5'b00000, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, cas_pkg::REG_OVER_LIMIT, 4'd0, 5'b00000, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b00000, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, cas_pkg::REG_RULE_MODE, 4'd0, 5'b00010, 1'b0, 1'b1, 1'b0, '0}
  };

  cave_automaton_stencil u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned walls_in_column(cas_pkg::column_t c, bit with_middle);
    int unsigned n;
    n = 0;
    if (c[cas_pkg::ColHasUpper] && c[cas_pkg::ColUpper]) n++;
    if (with_middle && c[cas_pkg::ColMiddle]) n++;
    if (c[cas_pkg::ColHasLower] && c[cas_pkg::ColLower]) n++;
    return n;
  endfunction

  function automatic cas_pkg::result_t judge_cell(cas_pkg::column_t mid,
                                                  cas_pkg::column_t lft, bit lp,
                                                  cas_pkg::column_t rgt, bit rp);
    cas_pkg::result_t r;
    int unsigned count;
    logic [cas_pkg::CodeWidth-1:0] self_code;
    bit corner;
    count = walls_in_column(mid, 1'b0);
    if (lp) count += walls_in_column(lft, 1'b1);
    if (rp) count += walls_in_column(rgt, 1'b1);
    self_code = mid[cas_pkg::ColMiddle] ? cas_pkg::CODE_WALL : cas_pkg::CODE_FLOOR;
    corner = (!lp || !rp) && (!mid[cas_pkg::ColHasUpper] || !mid[cas_pkg::ColHasLower]);
    case (live_cfg.rule_mode)
      cas_pkg::MODE_STEP: begin
        r.cell_code = (count <= live_cfg.under_limit || count > live_cfg.over_limit)
                      ? cas_pkg::CODE_WALL : cas_pkg::CODE_FLOOR;
      end
      cas_pkg::MODE_SMOOTH: begin
        r.cell_code = (!corner && count <= live_cfg.smooth_limit)
                      ? cas_pkg::CODE_FLOOR : self_code;
      end
      cas_pkg::MODE_HOLLOW: begin
        r.cell_code = (count == cas_pkg::FULL_COUNT) ? cas_pkg::CODE_EMPTY : self_code;
      end
      default: begin
        r.cell_code = self_code;
      end
    endcase
    r.wall_count = count[cas_pkg::CountWidth-1:0];
    r.run_last = 1'b0;
    return r;
  endfunction

  task automatic slide_window(input cas_pkg::column_t col, input bit first, input bit last,
                              output cas_pkg::result_t made[$]);
    made = {};
    if (mid_held) made = {made, judge_cell(mid_col, left_col, left_held, col, !first)};
    if (first || !mid_held) begin
      left_held = 1'b0;
      left_col = '0;
    end else begin
      left_col = mid_col;
      left_held = 1'b1;
    end
    mid_col = col;
    mid_held = 1'b1;
    if (last) begin
      made = {made, judge_cell(col, left_col, left_held, '0, 1'b0)};
      mid_held = 1'b0;
      left_held = 1'b0;
    end
    if (made.size() > 0) made[made.size()-1].run_last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic settle_block();
    s_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // leaves cfg_we high; the next column or settle lowers it
  task automatic write_register(input logic [cas_pkg::CfgIdxWidth-1:0] idx,
                                input logic [cas_pkg::CfgDataWidth-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      cas_pkg::REG_RULE_MODE:    live_cfg.rule_mode = value[cas_pkg::ModeWidth-1:0];
      cas_pkg::REG_UNDER_LIMIT:  live_cfg.under_limit = value;
      cas_pkg::REG_OVER_LIMIT:   live_cfg.over_limit = value;
      cas_pkg::REG_SMOOTH_LIMIT: live_cfg.smooth_limit = value;
      default: ;
    endcase
    settings_applied++;
  endtask

  task automatic offer_column(input cas_pkg::column_t col, input bit first, input bit last,
                              input bit typed, input cas_pkg::result_t want);
    int gap;
    cas_pkg::result_t made[$];
    gap = src_calm ? 0 : $urandom_range(0, 13);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, col};
    s_tuser <= first;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    slide_window(col, first, last, made);
    if (typed) awaited = {awaited, want};
    else awaited = {awaited, made};
    window_open = !last;
    columns_sent++;
  endtask

  function automatic logic [cas_pkg::CfgDataWidth-1:0] pick_limit();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 4'd15;
    if (r == 1) return 4'd0;
    return cas_pkg::CfgDataWidth'($urandom_range(0, 12));
  endfunction

  task automatic send_row(input int len, input bit drop_first, input bit drop_last);
    int density;
    bit up_on, low_on;
    cas_pkg::column_t col;
    density = $urandom_range(0, 4);
    up_on = $urandom_range(0, 3) != 0;
    low_on = $urandom_range(0, 3) != 0;
    for (int c = 0; c < len; c++) begin
      col[cas_pkg::ColUpper]    = $urandom_range(1, 4) <= density;
      col[cas_pkg::ColMiddle]   = $urandom_range(1, 4) <= density;
      col[cas_pkg::ColLower]    = $urandom_range(1, 4) <= density;
      col[cas_pkg::ColHasUpper] = ($urandom_range(0, 7) == 0) ? !up_on : up_on;
      col[cas_pkg::ColHasLower] = ($urandom_range(0, 7) == 0) ? !low_on : low_on;
      offer_column(col, c == 0 && !drop_first, c == len - 1 && !drop_last, 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    cas_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      cells_checked++;
      if (awaited.size() == 0) begin
        report_mismatch("result with none awaited, tdata", m_tdata, 0);
      end else begin
        want = awaited.pop_front();
        if (m_tdata[1:0] !== want.cell_code)
          report_mismatch("cell_code", m_tdata[1:0], want.cell_code);
        if (m_tdata[5:2] !== want.wall_count)
          report_mismatch("wall_count", m_tdata[5:2], want.wall_count);
        if (m_tlast !== want.run_last)
          report_mismatch("run_last", m_tlast, want.run_last);
      end
    end
  end

  // result sink with random stalls and one long hold-off
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_sink = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, awaited.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int kind;
    int phase_start;
    logic [cas_pkg::ModeWidth-1:0] mode;
    logic [1:0] junk;
    live_cfg = '{cas_pkg::MODE_STEP, cas_pkg::UNDER_RESET, cas_pkg::OVER_RESET,
                 cas_pkg::SMOOTH_RESET};
    left_col = '0;
    mid_col = '0;
    left_held = 1'b0;
    mid_held = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle_block();
        write_register(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        src_calm = 1'($urandom_range(0, 1));
        offer_column(directed_rows[i].col, directed_rows[i].first, directed_rows[i].last,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < Phases; ph++) begin
      settle_block();
      mode = cas_pkg::ModeWidth'(ph % 4);
      junk = 2'($urandom_range(0, 3));
      write_register(cas_pkg::REG_RULE_MODE, {junk, mode});
      write_register(cas_pkg::REG_UNDER_LIMIT, pick_limit());
      write_register(cas_pkg::REG_OVER_LIMIT, pick_limit());
      write_register(cas_pkg::REG_SMOOTH_LIMIT, pick_limit());
      if (ph == 5) hold_sink = 1'b1;
      phase_start = columns_sent;
      while (columns_sent - phase_start < PhaseColumns) begin
        kind = $urandom_range(0, 9);
        src_calm = $urandom_range(0, 3) == 0;
        if (kind < 8) begin
          send_row($urandom_range(1, 8), 1'b0, 1'b0);
        end else if (kind == 8) begin
          send_row($urandom_range(1, 6), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        end else begin
          offer_column(cas_pkg::column_t'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end
      // close the row so the next settings start on an empty window
      if (window_open)
        offer_column(cas_pkg::column_t'($urandom_range(0, 31)), 1'b0, 1'b1, 1'b0, '0);
    end

    settle_block();
    repeat (SettleCycles * 4) @(posedge clk);
    $display("sent %0d columns over %0d register writes covering all four rule modes",
             columns_sent, settings_applied);
    $display("compared %0d cell results, %0d mismatches", cells_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
